/* hw/rtl/csc_pkg.sv */
// shared constants and codes for the charlieplex pwm led scanner
package csc_pkg;

  localparam int NUM_PINS_DEF  = 6;
  localparam int PWM_STEPS_DEF = 16;
  localparam int IDX_W_DEF     = $clog2(NUM_PINS_DEF * (NUM_PINS_DEF - 1));
  localparam int DUTY_W_DEF    = $clog2(PWM_STEPS_DEF + 1);

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

endpackage

/* hw/rtl/csc_if.sv */
// valid/ready channel interfaces for scanner commands and pin results
interface csc_cmd_if #(
  parameter int IDX_W  = csc_pkg::IDX_W_DEF,
  parameter int DUTY_W = csc_pkg::DUTY_W_DEF
);
  logic              valid;
  logic              ready;
  logic              op;
  logic [IDX_W-1:0]  led_index;
  logic [DUTY_W-1:0] duty_value;

  modport source (output valid, output op, output led_index, output duty_value, input ready);
  modport sink   (input valid, input op, input led_index, input duty_value, output ready);
endinterface

interface csc_pins_if #(
  parameter int NUM_PINS = csc_pkg::NUM_PINS_DEF
);
  logic                valid;
  logic                ready;
  logic [NUM_PINS-1:0] pin_drive;
  logic [NUM_PINS-1:0] pin_level;

  modport source (output valid, output pin_drive, output pin_level, input ready);
  modport sink   (input valid, input pin_drive, input pin_level, output ready);
endinterface

/* hw/rtl/csc_duty_store.sv */
// per-led duty registers, cleared at reset, one write and one read port
module csc_duty_store #(
  parameter int LED_COUNT = 30,
  parameter int IDX_W     = 5,
  parameter int DUTY_W    = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DUTY_W-1:0] wr_data,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [DUTY_W-1:0] rd_data
);

  logic [DUTY_W-1:0] duty [LED_COUNT];

  // writes past the last led are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        duty[i] <= '0;
      end
    end else if (wr_en && ({1'b0, wr_addr} < (IDX_W+1)'(LED_COUNT))) begin
      duty[wr_addr] <= wr_data;
    end
  end

  assign rd_data = duty[rd_addr];

endmodule

/* hw/rtl/csc_scan_core.sv */
// scan state: pwm phase, row, column, led pointer and pin drive registers
module csc_scan_core #(
  parameter int NUM_PINS  = 6,
  parameter int PWM_STEPS = 16,
  parameter int LED_COUNT = 30,
  parameter int IDX_W     = 5,
  parameter int DUTY_W    = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick,
  input  logic [DUTY_W-1:0]   duty,
  output logic [IDX_W-1:0]    led_pointer,
  output logic [NUM_PINS-1:0] drive_next,
  output logic [NUM_PINS-1:0] level_next
);

  localparam int PH_W  = $clog2(PWM_STEPS);
  localparam int PIN_W = $clog2(NUM_PINS);

  logic [PH_W-1:0]     phase;
  logic [PIN_W-1:0]    row;
  logic [PIN_W-1:0]    column;
  logic [NUM_PINS-1:0] drive;
  logic [NUM_PINS-1:0] level;

  logic [PH_W-1:0]     phase_next;
  logic [PIN_W-1:0]    row_next;
  logic [PIN_W-1:0]    column_next;
  logic [IDX_W-1:0]    led_pointer_next;
  logic [PH_W:0]       phase_inc;
  logic [PIN_W:0]      column_inc;
  logic [PIN_W:0]      row_inc;
  logic [IDX_W:0]      pointer_inc;

  always_comb begin
    drive_next       = drive;
    level_next       = level;
    phase_next       = phase;
    row_next         = row;
    column_next      = column;
    led_pointer_next = led_pointer;
    phase_inc        = {1'b0, phase} + 1'b1;
    column_inc       = {1'b0, column} + 1'b1;
    row_inc          = {1'b0, row} + 1'b1;
    pointer_inc      = {1'b0, led_pointer} + 1'b1;
    if (tick) begin
      // duty match releases the column; zero duty takes this path at phase 0
      if (DUTY_W'(phase) == duty) begin
        drive_next[column] = 1'b0;
        level_next[column] = 1'b0;
      end else if (phase == '0) begin
        drive_next[row]    = 1'b1;
        level_next[row]    = 1'b0;
        drive_next[column] = 1'b1;
        level_next[column] = 1'b1;
      end
      phase_next = phase_inc[PH_W-1:0];
      if (phase_inc >= (PH_W+1)'(PWM_STEPS)) begin
        phase_next = '0;
        drive_next[column] = 1'b0;
        level_next[column] = 1'b0;
        if (pointer_inc >= (IDX_W+1)'(LED_COUNT)) begin
          led_pointer_next = '0;
        end else begin
          led_pointer_next = pointer_inc[IDX_W-1:0];
        end
        // skip the column that is the row pin
        if (column_inc == {1'b0, row}) begin
          column_inc = column_inc + 1'b1;
        end
        if (column_inc >= (PIN_W+1)'(NUM_PINS)) begin
          column_next     = '0;
          drive_next[row] = 1'b0;
          level_next[row] = 1'b0;
          if (row_inc >= (PIN_W+1)'(NUM_PINS)) begin
            row_next         = '0;
            column_next      = PIN_W'(1);
            led_pointer_next = '0;
          end else begin
            row_next = row_inc[PIN_W-1:0];
          end
        end else begin
          column_next = column_inc[PIN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      row         <= '0;
      column      <= PIN_W'(1);
      led_pointer <= '0;
      drive       <= '0;
      level       <= '0;
    end else if (tick) begin
      phase       <= phase_next;
      row         <= row_next;
      column      <= column_next;
      led_pointer <= led_pointer_next;
      drive       <= drive_next;
      level       <= level_next;
    end
  end

endmodule

/* hw/rtl/charlieplex_pwm_led_scanner.sv */
// top level: input register, duty store, scan core and pin result register
//
//  channel | dir | payload                          | item
//  cmd     | in  | op, led_index, duty_value        | one tick or one duty write
//  pins    | out | pin_drive, pin_level             | pin state after the item
//
// one item per cycle while pins ready is high; via input, then result register
// the scan update is one pass of compare and increment logic in the scan core
// rst is synchronous: scan at row 0 column 1, all pins floating, all duties zero
// a stalled result holds in its register; the input register takes one more item,
// then cmd ready drops until pins ready returns
module charlieplex_pwm_led_scanner #(
  parameter int NUM_PINS  = csc_pkg::NUM_PINS_DEF,
  parameter int PWM_STEPS = csc_pkg::PWM_STEPS_DEF
) (
  input logic        clk,
  input logic        rst,
  csc_cmd_if.sink    cmd,
  csc_pins_if.source pins
);

  localparam int LED_COUNT = NUM_PINS * (NUM_PINS - 1);
  localparam int IDX_W     = $clog2(LED_COUNT);
  localparam int DUTY_W    = $clog2(PWM_STEPS + 1);

  logic               in_valid;
  csc_pkg::op_t       op_q;
  logic [IDX_W-1:0]   idx_q;
  logic [DUTY_W-1:0]  duty_q;
  logic               out_valid;
  logic               fire;
  logic               tick;
  logic               wr_en;
  logic [IDX_W-1:0]   led_pointer;
  logic [DUTY_W-1:0]  led_duty;
  logic [NUM_PINS-1:0] drive_next;
  logic [NUM_PINS-1:0] level_next;
  logic [NUM_PINS-1:0] drive_q;
  logic [NUM_PINS-1:0] level_q;

  assign fire      = in_valid && (!out_valid || pins.ready);
  assign cmd.ready = !in_valid || fire;
  assign tick      = fire && (op_q == csc_pkg::OP_TICK);
  assign wr_en     = fire && (op_q == csc_pkg::OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
    if (cmd.valid && cmd.ready) begin
      op_q   <= csc_pkg::op_t'(cmd.op);
      idx_q  <= cmd.led_index;
      duty_q <= cmd.duty_value;
    end
  end

  csc_duty_store #(
    .LED_COUNT (LED_COUNT),
    .IDX_W     (IDX_W),
    .DUTY_W    (DUTY_W)
  ) u_duty_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (idx_q),
    .wr_data (duty_q),
    .rd_addr (led_pointer),
    .rd_data (led_duty)
  );

  csc_scan_core #(
    .NUM_PINS  (NUM_PINS),
    .PWM_STEPS (PWM_STEPS),
    .LED_COUNT (LED_COUNT),
    .IDX_W     (IDX_W),
    .DUTY_W    (DUTY_W)
  ) u_scan_core (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick),
    .duty        (led_duty),
    .led_pointer (led_pointer),
    .drive_next  (drive_next),
    .level_next  (level_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (pins.ready) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      drive_q <= drive_next;
      level_q <= level_next;
    end
  end

  assign pins.valid     = out_valid;
  assign pins.pin_drive = drive_q;
  assign pins.pin_level = level_q;

endmodule

/* hw/rtl/csc_checker.sv */
// port-level checks on the scanner result channel, bound to the top level
module csc_checker #(
  parameter int NUM_PINS = csc_pkg::NUM_PINS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                pins_valid,
  input logic                pins_ready,
  input logic [NUM_PINS-1:0] pin_drive,
  input logic [NUM_PINS-1:0] pin_level
);

  // a stalled item holds its pins
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pins_valid && !pins_ready |=> pins_valid && $stable(pin_drive) && $stable(pin_level))
    else $error("pins item changed while stalled");

  // a floating pin never reports high
  a_level_driven: assert property (@(posedge clk) disable iff (rst)
    pins_valid |-> ((pin_level & ~pin_drive) == '0))
    else $error("level bit set on a floating pin");

  // only one row and one column are ever driven
  a_two_driven: assert property (@(posedge clk) disable iff (rst)
    pins_valid |-> ($countones(pin_drive) <= 2) && ($countones(pin_level) <= 1))
    else $error("more than one led path driven");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pins_valid)
    else $error("pins item valid right after reset");

endmodule

bind charlieplex_pwm_led_scanner csc_checker #(
  .NUM_PINS (NUM_PINS)
) u_csc_checker (
  .clk        (clk),
  .rst        (rst),
  .pins_valid (pins.valid),
  .pins_ready (pins.ready),
  .pin_drive  (pins.pin_drive),
  .pin_level  (pins.pin_level)
);
